FILE: rtl/alarm_timer_table_top_defines.svh
// Assertion macros shared by the alarm timer table RTL.
`ifndef ALARM_TIMER_TABLE_TOP_DEFINES_SVH
`define ALARM_TIMER_TABLE_TOP_DEFINES_SVH

// Checks a condition at every clock edge outside reset.
`define ATT_ASSERT_ALWAYS(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Checks a consequence in the cycle after its trigger.
`define ATT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/att_pkg.sv
// Package with the types and constants of the alarm timer table.
`timescale 1ns / 1ps
package att_pkg;

   localparam int SLOTS    = 16;
   localparam int IDX_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W    = $clog2(SLOTS + 1);
   localparam int MAX_POLL = 16;

   typedef enum logic [2:0] {
      REQ_SCHEDULE = 3'd0,
      REQ_SNOOZE   = 3'd1,
      REQ_CANCEL   = 3'd2,
      REQ_ACK      = 3'd3,
      REQ_POLL     = 3'd4,
      REQ_QUERY    = 3'd5
   } req_kind_type;

   typedef enum logic [2:0] {
      PH_EMPTY  = 3'd0,
      PH_SCHED  = 3'd1,
      PH_FIRING = 3'd2,
      PH_ACK    = 3'd3,
      PH_CANCEL = 3'd4
   } phase_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SCAN = 4'b0010,
      ST_ACT  = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   typedef struct packed {
      logic [15:0] owner;
      logic [31:0] timer;
      logic [63:0] deadline;
      logic [31:0] revision;
      logic [31:0] fires;
      phase_type   phase;
   } entry_type;

endpackage

FILE: rtl/alarm_timer_table_top.sv
// Alarm timer table: entries live in a synchronous memory, one slot read per cycle
// unless a poll is held by a stalled result register. A request is answered after a walk
// over the filled slots, ending early when a lookup matches; the next request can be
// taken in the cycle its answer becomes valid. A poll fires entries during the walk and
// waits while the result register is stalled. One request is in work at a time.
// Reset clears the state, fill count, generation counter and valid flags, not the memory.
`timescale 1ns / 1ps
module alarm_timer_table_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_type,
   input  logic [15:0] req_owner_key,
   input  logic [31:0] req_timer_key,
   input  logic [63:0] req_duration_ms,
   input  logic [63:0] req_now_ms,
   input  logic [4:0]  req_max_deliveries,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_ok,
   output logic        rsp_delivered,
   output logic [15:0] rsp_fired_owner,
   output logic [31:0] rsp_fired_timer,
   output logic [63:0] rsp_fired_deadline,
   output logic [31:0] rsp_fired_revision,
   output logic [31:0] rsp_fire_ordinal,
   output logic [63:0] rsp_remaining,
   output logic [31:0] rsp_change_count,
   output logic        rsp_last
);
   import att_pkg::*;

   `include "alarm_timer_table_top_defines.svh"

   entry_type mem [SLOTS];
   entry_type rd_ff;

   state_type state_ff, state_in;
   logic [2:0]  typ_ff;
   logic [15:0] own_ff;
   logic [31:0] tmr_ff;
   logic [63:0] now_ff;
   logic [63:0] dl_ff;
   logic        dok_ff;
   logic [4:0]  lim_ff;
   logic [4:0]  k_ff, k_in;
   logic [CNT_W-1:0] used_ff, used_in;
   logic [CNT_W-1:0] nx_ff, nx_in;
   logic [IDX_W-1:0] ck_ff, ck_in;
   logic        v_ff, v_in;
   logic        found_ff, found_in;
   logic [31:0] gen_ff, gen_in;

   logic        rsp_valid_ff;
   logic        rsp_ok_ff, rsp_del_ff, rsp_last_ff;
   entry_type   rsp_ent_ff;
   logic [63:0] rsp_rem_ff;
   logic [31:0] rsp_chg_ff;

   logic        out_free, accept, more, hit, rd_en, we;
   logic [IDX_W-1:0] waddr;
   entry_type   wdata;
   logic        emit, e_ok, e_del, e_last;
   entry_type   e_ent;
   logic [63:0] e_rem;
   logic [64:0] sum;
   logic [31:0] gen_sat;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign more      = (nx_ff < used_ff);
   assign sum       = {1'b0, req_now_ms} + {1'b0, req_duration_ms};
   assign gen_sat   = (gen_ff == '1) ? gen_ff : gen_ff + 32'd1;
   assign hit = v_ff && ((typ_ff == REQ_POLL)
      ? (rd_ff.phase == PH_SCHED && rd_ff.deadline <= now_ff)
      : (rd_ff.owner == own_ff && rd_ff.timer == tmr_ff));

   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      used_in  = used_ff;
      nx_in    = nx_ff;
      ck_in    = ck_ff;
      v_in     = v_ff;
      found_in = found_ff;
      gen_in   = gen_ff;
      rd_en    = 1'b0;
      we       = 1'b0;
      waddr    = ck_ff;
      wdata    = rd_ff;
      emit     = 1'b0;
      e_ok     = 1'b0;
      e_del    = 1'b0;
      e_last   = 1'b1;
      e_ent    = '0;
      e_rem    = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               nx_in    = '0;
               v_in     = 1'b0;
               k_in     = '0;
               found_in = 1'b0;
               if (req_type == REQ_SCHEDULE || req_type == REQ_SNOOZE ||
                   req_type == REQ_CANCEL || req_type == REQ_ACK ||
                   req_type == REQ_POLL || req_type == REQ_QUERY) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_ACT;
               end
            end
         end
         ST_SCAN: begin
            if (hit && typ_ff != REQ_POLL) begin
               found_in = 1'b1;
               state_in = ST_ACT;
            end else if (hit && (k_ff >= lim_ff || rd_ff.fires == '1)) begin
               state_in = ST_DONE;
            end else if (hit && !out_free) begin
               state_in = ST_SCAN;
            end else begin
               if (hit) begin
                  wdata          = rd_ff;
                  wdata.phase    = PH_FIRING;
                  wdata.revision = rd_ff.revision + 32'd1;
                  wdata.fires    = rd_ff.fires + 32'd1;
                  we             = 1'b1;
                  waddr          = ck_ff;
                  gen_in         = gen_sat;
                  k_in           = k_ff + 5'd1;
                  emit           = 1'b1;
                  e_ok           = 1'b1;
                  e_del          = 1'b1;
                  e_last         = 1'b0;
                  e_ent          = wdata;
               end
               if (more) begin
                  rd_en = 1'b1;
                  ck_in = nx_ff[IDX_W-1:0];
                  nx_in = nx_ff + 1'b1;
                  v_in  = 1'b1;
               end else begin
                  v_in = 1'b0;
                  if (!v_ff) begin
                     state_in = (typ_ff == REQ_POLL) ? ST_DONE : ST_ACT;
                  end
               end
            end
         end
         ST_ACT: begin
            if (out_free) begin
               wdata = rd_ff;
               waddr = ck_ff;
               case (typ_ff)
                  REQ_SCHEDULE: begin
                     if (dok_ff && !found_ff && used_ff < CNT_W'(SLOTS)) begin
                        wdata.owner    = own_ff;
                        wdata.timer    = tmr_ff;
                        wdata.deadline = dl_ff;
                        wdata.revision = 32'd1;
                        wdata.fires    = 32'd0;
                        wdata.phase    = PH_SCHED;
                        waddr          = used_ff[IDX_W-1:0];
                        used_in        = used_ff + 1'b1;
                        we             = 1'b1;
                     end else if (dok_ff && found_ff &&
                                  (rd_ff.phase == PH_ACK || rd_ff.phase == PH_CANCEL)) begin
                        wdata.deadline = dl_ff;
                        wdata.revision = rd_ff.revision + 32'd1;
                        wdata.phase    = PH_SCHED;
                        we             = 1'b1;
                     end
                  end
                  REQ_SNOOZE: begin
                     if (dok_ff && found_ff && rd_ff.phase == PH_FIRING) begin
                        wdata.deadline = dl_ff;
                        wdata.revision = rd_ff.revision + 32'd1;
                        wdata.phase    = PH_SCHED;
                        we             = 1'b1;
                     end
                  end
                  REQ_CANCEL: begin
                     if (found_ff && (rd_ff.phase == PH_SCHED || rd_ff.phase == PH_FIRING)) begin
                        wdata.revision = rd_ff.revision + 32'd1;
                        wdata.phase    = PH_CANCEL;
                        we             = 1'b1;
                     end
                  end
                  REQ_ACK: begin
                     if (found_ff && rd_ff.phase == PH_FIRING) begin
                        wdata.revision = rd_ff.revision + 32'd1;
                        wdata.phase    = PH_ACK;
                        we             = 1'b1;
                     end
                  end
                  REQ_QUERY: begin
                     e_ok = found_ff;
                     if (found_ff && rd_ff.phase == PH_SCHED && rd_ff.deadline > now_ff) begin
                        e_rem = rd_ff.deadline - now_ff;
                     end
                  end
                  default: begin
                     e_ok = 1'b0;
                  end
               endcase
               if (we) begin
                  e_ok   = 1'b1;
                  gen_in = gen_sat;
               end
               emit     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               emit     = 1'b1;
               e_ok     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (rd_en) begin
         rd_ff <= mem[nx_ff[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         gen_ff       <= '0;
         v_ff         <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
         gen_ff   <= gen_in;
         v_ff     <= v_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      k_ff     <= k_in;
      nx_ff    <= nx_in;
      ck_ff    <= ck_in;
      found_ff <= found_in;
      if (accept) begin
         typ_ff <= req_type;
         own_ff <= req_owner_key;
         tmr_ff <= req_timer_key;
         now_ff <= req_now_ms;
         dl_ff  <= sum[63:0];
         dok_ff <= (req_duration_ms != 64'd0) && !sum[64];
         lim_ff <= (req_max_deliveries > 5'(MAX_POLL)) ? 5'(MAX_POLL) : req_max_deliveries;
      end
      if (emit) begin
         rsp_ok_ff   <= e_ok;
         rsp_del_ff  <= e_del;
         rsp_last_ff <= e_last;
         rsp_ent_ff  <= e_ent;
         rsp_rem_ff  <= e_rem;
         rsp_chg_ff  <= gen_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_ok             = rsp_ok_ff;
   assign rsp_delivered      = rsp_del_ff;
   assign rsp_fired_owner    = rsp_ent_ff.owner;
   assign rsp_fired_timer    = rsp_ent_ff.timer;
   assign rsp_fired_deadline = rsp_ent_ff.deadline;
   assign rsp_fired_revision = rsp_ent_ff.revision;
   assign rsp_fire_ordinal   = rsp_ent_ff.fires;
   assign rsp_remaining      = rsp_rem_ff;
   assign rsp_change_count   = rsp_chg_ff;
   assign rsp_last           = rsp_last_ff;

   `ATT_ASSERT_ALWAYS(a_used_bound, used_ff <= CNT_W'(SLOTS), "fill count beyond table size")
   `ATT_ASSERT_ALWAYS(a_read_range, !rd_en || (nx_ff < used_ff), "read of a slot never filled")
   `ATT_ASSERT_ALWAYS(a_fire_not_last, !(rsp_valid_ff && rsp_del_ff && rsp_last_ff), "bad word")

endmodule
